FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file rsti_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define RSTI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RSTI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/core/rsti_pkg.sv
package rsti_pkg;

    // Result word and alphabet sizing
    localparam int VALUE_W       = 32;
    localparam int MAX_BASE      = 16;
    localparam int STORE_SYMBOLS = 16;
    localparam int RADIX_CAP     = (MAX_BASE < STORE_SYMBOLS) ? MAX_BASE : STORE_SYMBOLS;
    localparam int RADIX_W       = $clog2(RADIX_CAP + 1);
    localparam int DIGIT_W       = $clog2(STORE_SYMBOLS);
    localparam int SYM_W         = 8;
    localparam int BASE_LEN_W    = 5;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    // Character codes
    localparam logic [SYM_W-1:0] CH_NUL   = 8'd0;
    localparam logic [SYM_W-1:0] CH_TAB   = 8'd9;
    localparam logic [SYM_W-1:0] CH_CR    = 8'd13;
    localparam logic [SYM_W-1:0] CH_SPACE = 8'd32;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_MIN  = 8'd33;
    localparam logic [SYM_W-1:0] SYM_MAX  = 8'd126;

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_SIGN,
        PH_DIGIT,
        PH_DONE
    } t_phase;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DIGITS_LOW,
        CFG_DIGITS_HIGH,
        CFG_BASE_LEN
    } t_cfg_index;

    // Digit lookup result for one byte
    typedef struct packed {
        logic               hit;
        logic [DIGIT_W-1:0] value;
    } t_digit_info;

endpackage

FILE: rtl/core/rsti_alphabet.sv
module rsti_alphabet
    import rsti_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CFG_DATA_W-1:0] i_digits_low,
    input  logic [CFG_DATA_W-1:0] i_digits_high,
    input  logic [BASE_LEN_W-1:0] i_base_len,
    input  logic [SYM_W-1:0]      i_ch,
    output t_digit_info           o_digit,
    output logic [RADIX_W-1:0]    o_radix,
    output logic                  o_base_ok
);

    logic [2*CFG_DATA_W-1:0] w_word;
    logic [SYM_W-1:0]        w_sym [STORE_SYMBOLS];
    logic [RADIX_W-1:0]      w_radix;
    logic                    n_base_ok;
    logic                    r_base_ok;

    assign w_word = {i_digits_high, i_digits_low};

    always_comb begin
        for (int i = 0; i < STORE_SYMBOLS; i++) begin
            w_sym[i] = w_word[i*SYM_W +: SYM_W];
        end
    end

    // Radix is the symbol count, clipped to the store size
    always_comb begin
        if (i_base_len > BASE_LEN_W'(RADIX_CAP)) begin
            w_radix = RADIX_W'(RADIX_CAP);
        end else begin
            w_radix = RADIX_W'(i_base_len);
        end
    end

    assign o_radix = w_radix;

    // Digit lookup: lowest matching position wins, NUL never matches
    always_comb begin
        o_digit = '0;
        for (int i = STORE_SYMBOLS - 1; i >= 0; i--) begin
            if (RADIX_W'(i) < w_radix && w_sym[i] == i_ch) begin
                o_digit.hit   = 1'b1;
                o_digit.value = DIGIT_W'(i);
            end
        end
        if (i_ch == CH_NUL) begin
            o_digit.hit = 1'b0;
        end
    end

    // Alphabet check: size, printable range, no sign chars, no duplicates
    always_comb begin
        n_base_ok = (w_radix >= RADIX_W'(2));
        for (int i = 0; i < STORE_SYMBOLS; i++) begin
            if (RADIX_W'(i) < w_radix) begin
                if (w_sym[i] < SYM_MIN || w_sym[i] > SYM_MAX ||
                    w_sym[i] == CH_PLUS || w_sym[i] == CH_MINUS) begin
                    n_base_ok = 1'b0;
                end
                for (int j = i + 1; j < STORE_SYMBOLS; j++) begin
                    if (RADIX_W'(j) < w_radix && w_sym[j] == w_sym[i]) begin
                        n_base_ok = 1'b0;
                    end
                end
            end
        end
    end

    // Registered; config must only change while idle, which the block does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_ok <= 1'b0;
        end else begin
            r_base_ok <= n_base_ok;
        end
    end

    assign o_base_ok = r_base_ok;

endmodule

FILE: rtl/core/radix_string_to_int.sv
// Each byte is accepted into the input register and parsed from there; a byte marked
// last waits while the result register is held, and its result is then registered.
// Throughput: one byte per cycle, set by the single accumulator multiply-add per byte,
// while no last byte waits. Reset: synchronous, active low; clears the parser, the
// pipeline valids and all configuration registers at once.
module radix_string_to_int
    import rsti_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // byte stream
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [SYM_W-1:0]            i_ch,
    input  logic                        i_last,
    // results
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [VALUE_W-1:0]   o_value,
    output logic                        o_base_ok,
    // configuration writes
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data
);

    // Configuration registers
    logic [CFG_DATA_W-1:0] r_digits_low;
    logic [CFG_DATA_W-1:0] r_digits_high;
    logic [BASE_LEN_W-1:0] r_base_len;

    // Input stage
    logic             r_in_vld;
    logic [SYM_W-1:0] r_ch;
    logic             r_last;

    // Parser state
    t_phase             r_phase;
    t_phase             n_phase;
    logic               r_neg;
    logic               n_neg;
    logic [VALUE_W-1:0] r_acc;
    logic [VALUE_W-1:0] n_acc;

    // Output stage
    logic               r_out_vld;
    logic [VALUE_W-1:0] r_value;
    logic               r_base_ok_out;

    logic               w_accept;
    logic               w_go;
    logic               w_out_free;
    logic               w_space;
    logic [VALUE_W-1:0] w_mac;
    logic [VALUE_W-1:0] w_result;
    t_digit_info        w_digit;
    logic [RADIX_W-1:0] w_radix;
    logic               w_base_ok;
    t_phase             w_phase;

    assign o_cfg_ready = 1'b1;

    // Configuration write transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits_low  <= '0;
            r_digits_high <= '0;
            r_base_len    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DIGITS_LOW:  r_digits_low  <= i_cfg_data;
                CFG_DIGITS_HIGH: r_digits_high <= i_cfg_data;
                CFG_BASE_LEN:    r_base_len    <= i_cfg_data[BASE_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    rsti_alphabet u_alphabet (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_digits_low  (r_digits_low),
        .i_digits_high (r_digits_high),
        .i_base_len    (r_base_len),
        .i_ch          (r_ch),
        .o_digit       (w_digit),
        .o_radix       (w_radix),
        .o_base_ok     (w_base_ok)
    );

    // Flow control: a last byte waits only if the result register is held
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_go       = r_in_vld && (!r_last || w_out_free);
    assign o_in_stall = r_in_vld && !w_go;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (w_go) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ch   <= i_ch;
            r_last <= i_last;
        end
    end

    // One parse step on the registered byte
    assign w_space = (r_ch == CH_SPACE) || (r_ch >= CH_TAB && r_ch <= CH_CR);
    assign w_mac   = r_acc * VALUE_W'(w_radix) + VALUE_W'(w_digit.value);

    always_comb begin
        w_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        if (w_phase == PH_SPACE && !w_space) begin
            w_phase = PH_SIGN;
        end
        if (w_phase == PH_SIGN) begin
            if (r_ch == CH_MINUS) begin
                n_neg = !r_neg;
            end else if (r_ch != CH_PLUS) begin
                w_phase = PH_DIGIT;
            end
        end
        if (w_phase == PH_DIGIT) begin
            if (w_digit.hit) begin
                n_acc = w_mac;
            end else begin
                w_phase = PH_DONE;
            end
        end
        n_phase  = w_phase;
        w_result = n_neg ? (~n_acc + VALUE_W'(1)) : n_acc;
    end

    // Parser state; rearms after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SPACE;
            r_neg   <= 1'b0;
            r_acc   <= '0;
        end else if (w_go) begin
            if (r_last) begin
                r_phase <= PH_SPACE;
                r_neg   <= 1'b0;
                r_acc   <= '0;
            end else begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_acc   <= n_acc;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_go && r_last) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && r_last) begin
            r_value       <= w_result;
            r_base_ok_out <= w_base_ok;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_value     = r_value;
    assign o_base_ok   = r_base_ok_out;

endmodule

FILE: rtl/core/rsti_checker.sv
`include "assert_macros.svh"

module rsti_checker
    import rsti_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      o_in_stall,
    input  logic [SYM_W-1:0]          i_ch,
    input  logic                      i_last,
    input  logic                      o_out_valid,
    input  logic                      i_out_stall,
    input  logic signed [VALUE_W-1:0] o_value,
    input  logic                      o_base_ok,
    input  logic                      i_cfg_valid,
    input  logic                      o_cfg_ready
);

    // Reset empties both stages
    `RSTI_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid && !o_in_stall, "not empty after reset")

    // Input only backs up behind a held result
    `RSTI_ASSERT(a_stall_cause, o_in_stall |-> o_out_valid && i_out_stall, "input stall without held result")

    // A held result stays put
    `RSTI_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_value) && $stable(o_base_ok), "held result changed")

    // A stalled byte transaction stays put
    `RSTI_ASSERT(a_in_hold, i_in_valid && o_in_stall |=> i_in_valid && $stable(i_ch) && $stable(i_last), "stalled input changed")

    // Configuration is never refused
    `RSTI_ASSERT(a_cfg_ready, i_cfg_valid |-> o_cfg_ready, "config write refused")

endmodule

bind radix_string_to_int rsti_checker u_rsti_checker (.*);
